/* hdl/bdq_pkg.sv */
// Shared types and constants of the bounded deque with search.
package bdq_pkg;

  localparam int unsigned OpcodeW = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  typedef enum logic [OpcodeW-1:0] {
    OP_INS_FRONT  = 3'd0,
    OP_INS_BACK   = 3'd1,
    OP_DEL_FRONT  = 3'd2,
    OP_DEL_BACK   = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_INS_UNIQUE = 3'd5,
    OP_READ_FRONT = 3'd6,
    OP_CLEAR      = 3'd7
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // latch the input beat and restart the scan
    logic scan_step; // issue one scan read and compare the previous one
    logic apply;     // carry out the operation
    logic front_rd;  // read the front slot
    logic out_load;  // load the result register
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_op;   // incoming opcode needs a membership scan
    logic scan_done; // scan found the value or ran past the last entry
    logic out_free;  // result register can take a new beat
  } sts_t;

endpackage

/* hdl/bdq_in_if.sv */
// Input channel: opcode and value with a valid/ready handshake.
interface bdq_in_if import bdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OpcodeW-1:0]       opcode;
  logic signed [ValueW-1:0] value;

  modport source (output valid, opcode, value, input ready);
  modport sink (input valid, opcode, value, output ready);
endinterface

/* hdl/bdq_out_if.sv */
// Result channel: status, found flag, front value and entry count.
interface bdq_out_if import bdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [StatusW-1:0]       status;
  logic                     found;
  logic signed [ValueW-1:0] front_value;
  logic [CountW-1:0]        entry_count;

  modport source (output valid, status, found, front_value, entry_count, input ready);
  modport sink (input valid, status, found, front_value, entry_count, output ready);
endinterface

/* hdl/bdq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bdq_ctrl.sv */
// Controller state machine: sequences load, scan, update, front read and result.
module bdq_ctrl import bdq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_FRONT,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = sts_i.scan_op ? S_SCAN : S_APPLY;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: state_d = S_FRONT;
      S_FRONT: state_d = S_RESP;
      S_RESP: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    ctl_o           = '0;
    ctl_o.load      = accept;
    ctl_o.scan_step = (state_q == S_SCAN) && !sts_i.scan_done;
    ctl_o.apply     = (state_q == S_APPLY);
    ctl_o.front_rd  = (state_q == S_FRONT);
    ctl_o.out_load  = (state_q == S_RESP) && sts_i.out_free;
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/bdq_dpath.sv */
// Datapath: ring pointers, entry store, scan compare and result register.
module bdq_dpath import bdq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctl_t                     ctl_i,
  output sts_t                     sts_o,
  input  logic [OpcodeW-1:0]       in_opcode_i,
  input  logic signed [ValueW-1:0] in_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [StatusW-1:0]       out_status_o,
  output logic                     out_found_o,
  output logic signed [ValueW-1:0] out_front_value_o,
  output logic [CountW-1:0]        out_entry_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Wrap a sum below twice DEPTH back into the ring
  function automatic logic [AW-1:0] wrap(input logic [AW:0] sum);
    logic [AW:0] adj;
    adj = sum;
    if (sum >= (AW+1)'(DEPTH)) begin
      adj = sum - (AW+1)'(DEPTH);
    end
    return adj[AW-1:0];
  endfunction

  logic [OpcodeW-1:0] op_q;
  logic [ValueW-1:0]  val_q;
  logic [AW-1:0]      head_q, head_d;
  logic [CW-1:0]      occ_q, occ_d;
  logic [CW-1:0]      idx_q;
  logic               pend_q, hit_q;
  logic [StatusW-1:0] status_q, status_d;
  logic               found_q, found_d;
  logic               out_valid_q;
  logic [StatusW-1:0] res_status_q;
  logic               res_found_q;
  logic [ValueW-1:0]  res_front_q;
  logic [CountW-1:0]  res_count_q;

  logic              full, empty;
  logic              scan_issue, match;
  logic [AW-1:0]     scan_slot, back_slot, head_dec, head_inc;
  logic              we;
  logic [AW-1:0]     waddr;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [ValueW-1:0] rdata;

  assign full  = (occ_q == CW'(DEPTH));
  assign empty = (occ_q == '0);

  assign scan_slot = wrap({1'b0, head_q} + (AW+1)'(idx_q));
  assign back_slot = wrap({1'b0, head_q} + (AW+1)'(occ_q));
  assign head_inc  = wrap({1'b0, head_q} + (AW+1)'(1));
  assign head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);

  assign scan_issue = ctl_i.scan_step && (idx_q < occ_q) && !hit_q;
  assign match      = pend_q && (rdata == val_q);

  // Carry out the operation on the pointers and the store
  always_comb begin
    head_d   = head_q;
    occ_d    = occ_q;
    status_d = ST_OK;
    found_d  = 1'b0;
    we       = 1'b0;
    waddr    = back_slot;
    unique case (opcode_e'(op_q))
      OP_INS_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          head_d = head_dec;
          waddr  = head_dec;
          we     = 1'b1;
          occ_d  = occ_q + CW'(1);
        end
      end
      OP_INS_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we    = 1'b1;
          occ_d = occ_q + CW'(1);
        end
      end
      OP_DEL_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          head_d = head_inc;
          occ_d  = occ_q - CW'(1);
        end
      end
      OP_DEL_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          occ_d = occ_q - CW'(1);
        end
      end
      OP_SEARCH: begin
        found_d = hit_q;
      end
      OP_INS_UNIQUE: begin
        if (hit_q) begin
          found_d = 1'b1;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          we    = 1'b1;
          occ_d = occ_q + CW'(1);
        end
      end
      OP_READ_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end
      end
      OP_CLEAR: begin
        head_d = '0;
        occ_d  = '0;
      end
      default: ;
    endcase
  end

  // Read port serves the scan and the front read
  assign re    = scan_issue || ctl_i.front_rd;
  assign raddr = ctl_i.front_rd ? head_q : scan_slot;

  bdq_ram #(
    .WIDTH (ValueW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.apply && we),
    .waddr_i (waddr),
    .wdata_i (val_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      occ_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.load) begin
        idx_q  <= '0;
        pend_q <= 1'b0;
        hit_q  <= 1'b0;
      end else if (ctl_i.scan_step) begin
        pend_q <= scan_issue;
        hit_q  <= hit_q || match;
        if (scan_issue) begin
          idx_q <= idx_q + CW'(1);
        end
      end
      if (ctl_i.apply) begin
        head_q <= head_d;
        occ_q  <= occ_d;
      end
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q  <= in_opcode_i;
      val_q <= in_value_i;
    end
    if (ctl_i.apply) begin
      status_q <= status_d;
      found_q  <= found_d;
    end
    if (ctl_i.out_load) begin
      res_status_q <= status_q;
      res_found_q  <= found_q;
      res_front_q  <= empty ? '0 : rdata;
      res_count_q  <= CountW'(occ_q);
    end
  end

  assign sts_o.scan_op   = (opcode_e'(in_opcode_i) == OP_SEARCH) ||
                           (opcode_e'(in_opcode_i) == OP_INS_UNIQUE);
  assign sts_o.scan_done = hit_q || ((idx_q >= occ_q) && !pend_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = res_status_q;
  assign out_found_o       = res_found_q;
  assign out_front_value_o = res_front_q;
  assign out_entry_count_o = res_count_q;

endmodule

/* hdl/bounded_deque_with_search.sv */
// Top level of the bounded deque with search: controller, datapath and channels.
//
// Usage: items arrive on in_i (opcode, value) and each gives exactly one
// result beat on out_o (status, found, front_value, entry_count), in order.
// The deque holds up to DEPTH signed 32-bit entries in a ring RAM addressed
// by a head pointer and an occupancy count.
// Flow: one item at a time. A non-search item passes the apply, front-read
// and result states before its result is loaded into the output register,
// and the next item is accepted once the controller is back in idle. A
// search or insert-if-absent first scans the held entries through the
// single RAM read port, one entry per cycle; a hit ends the scan early.
// in_i.ready is high while the controller is idle.
// The result sits in an output register: the next item is accepted while the
// previous result still waits, so a stalled receiver costs nothing until the
// following result is ready; that one then waits until out_o.ready frees the
// register.
// Reset: the deque is empty, head at slot 0, no result pending. Entry data is
// not cleared; an empty deque reports a zero front value in place of the slot read.
module bounded_deque_with_search import bdq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdq_in_if.sink    in_i,
  bdq_out_if.source out_o
);

  ctl_t ctl;
  sts_t sts;

  bdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  bdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .in_opcode_i       (in_i.opcode),
    .in_value_i        (in_i.value),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .out_status_o      (out_o.status),
    .out_found_o       (out_o.found),
    .out_front_value_o (out_o.front_value),
    .out_entry_count_o (out_o.entry_count)
  );

endmodule

/* hdl/bdq_checker.sv */
// Port-level checker of the bounded deque with search, and its bind.
module bdq_port_checks import bdq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [StatusW-1:0]       out_status_i,
  input logic                     out_found_i,
  input logic signed [ValueW-1:0] out_front_value_i,
  input logic [CountW-1:0]        out_entry_count_i
);

  // A dropped insert leaves the deque full
  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == ST_FULL) |-> out_entry_count_i == CountW'(DEPTH))
    else $error("full status with entry count below depth");

  // An ignored remove or read leaves the deque empty
  a_empty_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == ST_EMPTY) |->
      (out_entry_count_i == '0) && (out_front_value_i == '0) && !out_found_i)
    else $error("empty status with entries or front value");

  // An empty deque shows a zero front value
  a_empty_front : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_entry_count_i == '0) |-> out_front_value_i == '0)
    else $error("nonzero front value on empty deque");

  // A found value always comes with status ok
  a_found_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_found_i |-> out_status_i == ST_OK)
    else $error("found flag with error status");

  // Hold a stalled result beat
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) &&
      $stable(out_found_i) && $stable(out_front_value_i) && $stable(out_entry_count_i))
    else $error("result beat changed while stalled");

endmodule

bind bounded_deque_with_search bdq_port_checks #(
  .DEPTH (DEPTH)
) u_bdq_port_checks (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_status_i      (out_o.status),
  .out_found_i       (out_o.found),
  .out_front_value_i (out_o.front_value),
  .out_entry_count_i (out_o.entry_count)
);

/* verif/bdq_checker.sv */
`timescale 1ns / 1ps
// Reply predictor and checker for the bounded deque with search.
module bdq_checker import bdq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdq_in_if           in_i,
  bdq_out_if          out_i,
  output int unsigned mismatch_count_o,
  output int unsigned replies_owed_o
);

  typedef struct packed {
    status_e             status;
    logic                found;
    logic [ValueW-1:0]   front_value;
    logic [CountW-1:0]   entry_count;
  } deque_reply_t;

  // Shadow copy of the deque contents
  logic [ValueW-1:0] slots [DEPTH];
  int unsigned       head_slot;
  int unsigned       held;

  // Replies predicted but not yet seen on the result channel
  deque_reply_t      replies_q [$];

  initial begin
    for (int i = 0; i < DEPTH; i++) slots[i] = '0;
  end

  // Scan the held entries from the front for a matching bit pattern
  function automatic bit value_held(logic [ValueW-1:0] val);
    for (int unsigned i = 0; i < held; i++) begin
      if (slots[(head_slot + i) % DEPTH] == val) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic status_e append_value(logic [ValueW-1:0] val);
    if (held >= DEPTH) return ST_FULL;
    slots[(head_slot + held) % DEPTH] = val;
    held++;
    return ST_OK;
  endfunction

  // Apply one operation to the shadow deque and form its reply
  function automatic deque_reply_t predict_reply(opcode_e op, logic [ValueW-1:0] val);
    deque_reply_t rep;
    rep.status = ST_OK;
    rep.found  = 1'b0;
    case (op)
      OP_INS_FRONT: begin
        if (held >= DEPTH) begin
          rep.status = ST_FULL;
        end else begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          slots[head_slot] = val;
          held++;
        end
      end
      OP_INS_BACK: rep.status = append_value(val);
      OP_DEL_FRONT: begin
        if (held == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          head_slot = (head_slot + 1) % DEPTH;
          held--;
        end
      end
      OP_DEL_BACK: begin
        if (held == 0) rep.status = ST_EMPTY;
        else held--;
      end
      OP_SEARCH: rep.found = value_held(val);
      OP_INS_UNIQUE: begin
        if (value_held(val)) rep.found = 1'b1;
        else rep.status = append_value(val);
      end
      OP_READ_FRONT: begin
        if (held == 0) rep.status = ST_EMPTY;
      end
      default: begin
        head_slot = 0;
        held      = 0;
      end
    endcase
    rep.front_value = (held != 0) ? slots[head_slot] : '0;
    rep.entry_count = CountW'(held);
    return rep;
  endfunction

  // Predict on each input beat, compare each result beat with the oldest reply
  always @(posedge clk_i or negedge rst_ni) begin : track_replies
    deque_reply_t got;
    deque_reply_t want;
    int unsigned  errs;
    if (!rst_ni) begin
      head_slot = 0;
      held      = 0;
      replies_q.delete();
      replies_owed_o   <= 0;
      mismatch_count_o <= 0;
    end else begin
      errs = 0;
      if (in_i.valid && in_i.ready) begin
        replies_q.push_back(predict_reply(opcode_e'(in_i.opcode), in_i.value));
      end
      if (out_i.valid && out_i.ready) begin
        got.status      = status_e'(out_i.status);
        got.found       = out_i.found;
        got.front_value = out_i.front_value;
        got.entry_count = out_i.entry_count;
        if (replies_q.size() == 0) begin
          $display("%0t: result beat with no reply pending, got status %0d found %0d front %h count %0d",
                   $time, got.status, got.found, got.front_value, got.entry_count);
          errs++;
        end else begin
          want = replies_q.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            errs++;
          end
          if (got.found !== want.found) begin
            $display("%0t: found mismatch, expected %0d, actual %0d",
                     $time, want.found, got.found);
            errs++;
          end
          if (got.front_value !== want.front_value) begin
            $display("%0t: front_value mismatch, expected %h, actual %h",
                     $time, want.front_value, got.front_value);
            errs++;
          end
          if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                     $time, want.entry_count, got.entry_count);
            errs++;
          end
        end
      end
      mismatch_count_o <= mismatch_count_o + errs;
      replies_owed_o   <= replies_q.size();
    end
  end

endmodule

/* verif/bounded_deque_with_search_test.sv */
`timescale 1ns / 1ps
// Stimulus, clock, reset and verdict for the bounded deque with search.
module bounded_deque_with_search_test;
  import bdq_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int unsigned PhaseItems = 388;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 30;

  // Sender idle and receiver stall percentages per phase
  localparam int unsigned SendIdle [4] = '{0, 71, 0, 29};
  localparam int unsigned RecvStall[4] = '{0, 0, 71, 29};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count;
  int unsigned replies_owed;

  // Values reused often so that searches and unique inserts hit
  logic [ValueW-1:0] value_pool [8];

  bdq_in_if  in_ch ();
  bdq_out_if out_ch ();

  bounded_deque_with_search #(.DEPTH(Depth)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  bdq_checker #(.DEPTH(Depth)) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (in_ch),
    .out_i            (out_ch),
    .mismatch_count_o (mismatch_count),
    .replies_owed_o   (replies_owed)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Abort a hung run
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("simulation failed");
    $finish;
  end

  // Idle at random, then present one beat and hold it until accepted
  task automatic send_item(opcode_e op, logic [ValueW-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.value  <= val;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Drop valid and hold off until every reply has come back
  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (replies_owed != 0) @(posedge clk_i);
  endtask

  // Empty-deque cases, a fill to capacity with the extreme values, then full-deque cases
  task automatic run_directed();
    opcode_e           op;
    logic [ValueW-1:0] val;
    send_item(OP_READ_FRONT, 32'h0000_0005);
    send_item(OP_DEL_FRONT, '0);
    send_item(OP_DEL_BACK, '1);
    send_item(OP_SEARCH, '1);
    for (int i = 0; i < Depth; i++) begin
      case (i % 3)
        0:       op = OP_INS_FRONT;
        1:       op = OP_INS_BACK;
        default: op = OP_INS_UNIQUE;
      endcase
      case (i)
        0:       val = 32'h7fff_ffff;
        1:       val = 32'h8000_0000;
        2:       val = 32'h0000_0000;
        3:       val = 32'hffff_ffff;
        default: val = $urandom();
      endcase
      send_item(op, val);
    end
    send_item(OP_INS_FRONT, 32'h1234_5678);
    send_item(OP_INS_BACK, 32'h5a5a_a5a5);
    send_item(OP_INS_UNIQUE, 32'h8000_0000);
    send_item(OP_INS_UNIQUE, 32'h0bad_cafe);
    send_item(OP_SEARCH, 32'h7fff_ffff);
    send_item(OP_CLEAR, $urandom());
  endtask

  // Bias inserts or removes so the deque swings between empty and full
  function automatic opcode_e pick_op(bit filling);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 2)  return OP_CLEAR;
    if (roll < 12) return OP_SEARCH;
    if (roll < 18) return OP_READ_FRONT;
    if (roll < 26) return OP_INS_UNIQUE;
    if (filling) begin
      if (roll < 51) return OP_INS_FRONT;
      if (roll < 76) return OP_INS_BACK;
      if (roll < 88) return OP_DEL_FRONT;
      return OP_DEL_BACK;
    end
    if (roll < 38) return OP_INS_FRONT;
    if (roll < 50) return OP_INS_BACK;
    if (roll < 75) return OP_DEL_FRONT;
    return OP_DEL_BACK;
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    if ($urandom_range(1)) return value_pool[$urandom_range(7)];
    return $urandom();
  endfunction

  task automatic run_random(int unsigned count);
    bit          filling;
    int unsigned run_left;
    filling  = 1'b1;
    run_left = $urandom_range(60, 20);
    value_pool[0] = 32'h7fff_ffff;
    value_pool[1] = 32'h8000_0000;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom();
    repeat (count) begin
      if (run_left == 0) begin
        filling  = !filling;
        run_left = $urandom_range(60, 20);
      end
      run_left--;
      send_item(pick_op(filling), pick_value());
    end
  endtask

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.opcode <= '0;
    in_ch.value  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    drain_replies();
    // Sweep the idle and stall mixes, draining fully between phases
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SendIdle[p];
      stall_pct     = RecvStall[p];
      run_random(PhaseItems);
      drain_replies();
    end
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && replies_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
